>>> rtl/selective_repeat_ack_tracker_core_assert.svh
// assertion macros used by the ack tracker rtl
`ifndef SELECTIVE_REPEAT_ACK_TRACKER_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_ACK_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SRAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srat assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define SRAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srat assertion failed");

`endif

>>> rtl/srat_pkg.sv
// shared types, codes and constants of the ack tracker
package srat_pkg;

	localparam int WINDOW_SLOTS = 5;
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam logic [7:0] MSG_TYPE_ACK = 8'd2;

	typedef enum logic [2:0] {
		ST_INVALID  = 3'd0,
		ST_ADVANCED = 3'd1,
		ST_BUFFERED = 3'd2,
		ST_OUTSIDE  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] msg_checksum;
		logic [7:0]  msg_type;
		logic [30:0] ack_index;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] last_acked;
		logic               done_res;
	} out_item_t;

	// result flags of the shared subtract-compare unit
	typedef struct packed {
		logic eq_zero;
		logic eq_one;
		logic neg;
		logic in_win;
	} cmp_flags_t;

endpackage

>>> rtl/selective_repeat_ack_tracker_core.sv
// top level of the selective repeat ack tracker: sequencer, slot buffer, result register
// flow from accept to result valid: check, then response for invalid or outside window;
// in-order acks drain the chained slots, in-window acks scan for a copy or a free slot
// scans visit one slot per cycle via the shared compare unit; idle takes the next request
// in the cycle after the result loads, so a new request waits until the last one is done
// arst_n clears the sequencer, the slot used bits, cumulative ack (-1) and total_packets (1)
module selective_repeat_ack_tracker_core
	import srat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

`include "selective_repeat_ack_tracker_core_assert.svh"

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_DRAIN = 5'b00100,
		S_SCAN  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;

	// request held while it is worked on
	in_item_t req_q;

	// cumulative ack, -1 before any
	logic signed [31:0] cum_q;
	// total_packets - 1, kept ready for the done compare
	logic signed [32:0] tot_m1_q;

	// out-of-order slot buffer
	logic [30:0]             slot_idx_q [WINDOW_SLOTS];
	logic [WINDOW_SLOTS-1:0] used_q;

	// scan pointer and counters
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] miss_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_ptr_q;

	status_t status_q;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	// shared compare unit hookup
	logic signed [32:0] opa;
	logic signed [32:0] opb;
	cmp_flags_t         flags;

	logic [10:0] byte_sum;
	logic        msg_ok;
	logic        ptr_last;
	logic        cur_used;
	logic        accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checksum is the plain byte sum of the type and the four big-endian index bytes
	assign byte_sum = 11'(req_q.msg_type)
		+ 11'({1'b0, req_q.ack_index[30:24]})
		+ 11'(req_q.ack_index[23:16])
		+ 11'(req_q.ack_index[15:8])
		+ 11'(req_q.ack_index[7:0]);
	assign msg_ok = (req_q.msg_type == MSG_TYPE_ACK)
		&& (req_q.msg_checksum == {21'd0, byte_sum});

	assign ptr_last = (ptr_q == SLOT_W'(WINDOW_SLOTS - 1));
	assign cur_used = used_q[ptr_q];

	// operand select per sequencer step
	always_comb begin
		unique case (state_q)
			S_CHECK: begin
				// index relative to cumulative ack
				opa = $signed({2'b00, req_q.ack_index});
				opb = 33'(cum_q);
			end
			S_DRAIN: begin
				// slot holding the next expected index
				opa = $signed({2'b00, slot_idx_q[ptr_q]});
				opb = 33'(cum_q);
			end
			S_SCAN: begin
				// duplicate search
				opa = $signed({2'b00, slot_idx_q[ptr_q]});
				opb = $signed({2'b00, req_q.ack_index});
			end
			default: begin
				// done flag: cum - (total - 1) >= 0
				opa = 33'(cum_q);
				opb = tot_m1_q;
			end
		endcase
	end

	srat_cmp_unit u_cmp (
		.opa   (opa),
		.opb   (opb),
		.flags (flags)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_m1_q <= 33'sd0;
		end else if (cfg_we) begin
			tot_m1_q <= $signed({2'b00, cfg_wdata}) - 33'sd1;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
	end

	// slot contents, written only when an index gets buffered
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && ptr_last && !(cur_used && flags.eq_zero)) begin
			if (free_found_q) begin
				slot_idx_q[free_ptr_q] <= req_q.ack_index;
			end else if (!cur_used) begin
				slot_idx_q[ptr_q] <= req_q.ack_index;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cum_q        <= '1;
			used_q       <= '0;
			ptr_q        <= '0;
			miss_q       <= '0;
			free_found_q <= 1'b0;
			free_ptr_q   <= '0;
			status_q     <= ST_INVALID;
			out_valid_q  <= 1'b0;
		end else begin
			// the response step sets valid itself
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					ptr_q        <= '0;
					miss_q       <= '0;
					free_found_q <= 1'b0;
					if (!msg_ok) begin
						status_q <= ST_INVALID;
						state_q  <= S_RESP;
					end else if (flags.eq_one) begin
						// in-order ack moves the cumulative index, then chase the chain
						cum_q    <= $signed({1'b0, req_q.ack_index});
						status_q <= ST_ADVANCED;
						state_q  <= S_DRAIN;
					end else if (flags.in_win) begin
						state_q <= S_SCAN;
					end else begin
						status_q <= ST_OUTSIDE;
						state_q  <= S_RESP;
					end
				end
				S_DRAIN: begin
					ptr_q <= ptr_last ? '0 : ptr_q + 1'b1;
					if (cur_used && flags.eq_one) begin
						cum_q         <= $signed({1'b0, slot_idx_q[ptr_q]});
						used_q[ptr_q] <= 1'b0;
						miss_q        <= '0;
					end else if (miss_q == SLOT_W'(WINDOW_SLOTS - 1)) begin
						// a full lap with no match ends the chain
						state_q <= S_RESP;
					end else begin
						miss_q <= miss_q + 1'b1;
					end
				end
				S_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (!cur_used && !free_found_q) begin
						free_found_q <= 1'b1;
						free_ptr_q   <= ptr_q;
					end
					if (cur_used && flags.eq_zero) begin
						// already held, keep the single copy
						status_q <= ST_BUFFERED;
						state_q  <= S_RESP;
					end else if (ptr_last) begin
						state_q <= S_RESP;
						if (free_found_q) begin
							used_q[free_ptr_q] <= 1'b1;
							status_q           <= ST_BUFFERED;
						end else if (!cur_used) begin
							used_q[ptr_q] <= 1'b1;
							status_q      <= ST_BUFFERED;
						end else begin
							status_q <= ST_FULL;
						end
					end
				end
				S_RESP: begin
					// wait for the result register to drain
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_q.status     <= status_q;
			out_q.last_acked <= cum_q;
			out_q.done_res   <= !flags.neg;
		end
	end

	// an accepted request always starts with the classify step
	`SRAT_ASSERT_NEXT(a_accept_check, clk, arst_n, accept, state_q == S_CHECK)
	// a rejected message leaves the cumulative ack alone
	`SRAT_ASSERT_NEXT(a_invalid_keeps_cum, clk, arst_n, state_q == S_CHECK && !msg_ok,
		$stable(cum_q))
	// draining moves the cumulative ack by at most one per cycle
	`SRAT_ASSERT_NEXT(a_drain_step, clk, arst_n, state_q == S_DRAIN,
		cum_q == $past(cum_q) || cum_q == $past(cum_q) + 32'sd1)
	// the store scan never frees a slot
	`SRAT_ASSERT_NEXT(a_scan_no_free, clk, arst_n, state_q == S_SCAN,
		$countones(used_q) >= $past($countones(used_q)))

endmodule

>>> rtl/srat_cmp_unit.sv
// shared subtract and compare unit: a - b with window flags
module srat_cmp_unit
	import srat_pkg::*;
(
	input  logic signed [32:0] opa,
	input  logic signed [32:0] opb,
	output cmp_flags_t         flags
);

	logic signed [32:0] diff;

	assign diff = opa - opb;

	always_comb begin
		flags.eq_zero = (diff == 33'sd0);
		flags.eq_one  = (diff == 33'sd1);
		flags.neg     = diff[32];
		// strictly beyond the next index and no farther than the window end
		flags.in_win  = (diff > 33'sd1) && (diff <= 33'(WINDOW_SLOTS));
	end

endmodule
